// File: hdl/indexed_array_list_assert.svh
// indexed_array_list_assert.svh: assertion macros for the indexed array list.
// Relies on clk and rst_n being visible where a macro is used.
`ifndef INDEXED_ARRAY_LIST_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define IAL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define IAL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/iacl_pkg.sv
// iacl_pkg: widths, codes and the cell command type of the indexed array list.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package iacl_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_WRITE,
        CELL_ROTATE
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t                  op;
        logic [POS_W-1:0]          pos;
        logic [COUNT_W-1:0]        count;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

// File: hdl/iacl_cell.sv
// iacl_cell: one entry of the list, with its own shift and load decision.
// Depends on iacl_pkg.
`timescale 1ns / 1ps

module iacl_cell #(
    parameter int INDEX = 0
) (
    input  logic                              clk,
    input  iacl_pkg::cell_cmd_t               cmd,
    input  logic signed [iacl_pkg::DATA_W-1:0] left,
    input  logic signed [iacl_pkg::DATA_W-1:0] right,
    output logic signed [iacl_pkg::DATA_W-1:0] q
);
    import iacl_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                // open a gap at pos, later live entries move up one
                if (IDX == cmd.pos)
                begin
                    entry_next = cmd.value;
                end
                else if (IDX > cmd.pos && IDX <= cmd.count)
                begin
                    entry_next = left;
                end
            end
            CELL_DELETE:
            begin
                if (IDX >= cmd.pos && (IDX + 1'b1) < cmd.count)
                begin
                    entry_next = right;
                end
            end
            CELL_WRITE:
            begin
                if (IDX == cmd.pos)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// File: hdl/iacl_chain.sv
// iacl_chain: the ring of list cells; cell 0 is the head seen by the controller.
// Depends on iacl_pkg and iacl_cell.
`timescale 1ns / 1ps

module iacl_chain #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  iacl_pkg::cell_cmd_t               cmd,
    output logic signed [iacl_pkg::DATA_W-1:0] head
);
    import iacl_pkg::*;

    logic signed [DATA_W-1:0] q [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        iacl_cell #(
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .left  (q[(i + CAPACITY - 1) % CAPACITY]),
            .right (q[(i + 1) % CAPACITY]),
            .q     (q[i])
        );
    end

    assign head = q[0];

endmodule

// File: hdl/indexed_array_list.sv
// indexed_array_list: top level, request sequencer and result register.
// Depends on iacl_pkg, iacl_chain and indexed_array_list_assert.svh.
//
// Use: an ordered list of signed 32-bit entries held in a ring of CAPACITY
// cells. A request transfer (req_valid high, req_stall low) carries action,
// position and value; each request yields exactly one response transfer
// (rsp_valid high, rsp_stall low) with status, found_position, read_value and
// entry_count (live entries after the request).
// Timing: insert, delete and write update the cells in the accept cycle;
// rejected requests and unused action codes leave them as they are. The
// response passes through S_DONE into the output register. Find and an
// in-range read rotate the whole ring once, one cell step per cycle,
// comparing or capturing at cell 0; the ring comes back to its original order.
// That single ring pass makes find and read the slowest requests.
// Requests are taken one at a time; req_stall is high while a request is in
// work. A finished response waits in the output register under rsp_stall while
// the next request is already accepted and worked on; it then waits for the
// register to free.
// Reset clears the live count and all control; cell contents are left as is
// and are only ever read below the live count.
`timescale 1ns / 1ps
`include "indexed_array_list_assert.svh"

module indexed_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic [iacl_pkg::ACTION_W-1:0]         action,
    input  logic [iacl_pkg::POS_W-1:0]            position,
    input  logic signed [iacl_pkg::DATA_W-1:0]    value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [iacl_pkg::STATUS_W-1:0]         status,
    output logic [iacl_pkg::POS_W-1:0]            found_position,
    output logic signed [iacl_pkg::DATA_W-1:0]    read_value,
    output logic [iacl_pkg::COUNT_W-1:0]          entry_count
);
    import iacl_pkg::*;

    localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CAPACITY - 1);
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_DONE
    } state_t;

    state_t                   state_reg,   state_next;
    logic [COUNT_W-1:0]       count_reg,   count_next;
    logic [STEP_W-1:0]        step_reg,    step_next;
    logic [ACTION_W-1:0]      act_reg,     act_next;
    logic [POS_W-1:0]         pos_reg,     pos_next;
    logic signed [DATA_W-1:0] val_reg,     val_next;
    logic                     hit_reg,     hit_next;
    logic [STATUS_W-1:0]      res_st_reg,  res_st_next;
    logic [POS_W-1:0]         res_pos_reg, res_pos_next;
    logic signed [DATA_W-1:0] res_rd_reg,  res_rd_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]      status_reg,    status_next;
    logic [POS_W-1:0]         found_reg,     found_next;
    logic signed [DATA_W-1:0] read_reg,      read_next;
    logic [COUNT_W-1:0]       ecount_reg,    ecount_next;

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] head;
    logic                     req_take;
    logic                     rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid_reg && !rsp_stall;

    iacl_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk  (clk),
        .cmd  (cmd),
        .head (head)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        hit_next       = hit_reg;
        res_st_next    = res_st_reg;
        res_pos_next   = res_pos_reg;
        res_rd_next    = res_rd_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        read_next      = read_reg;
        ecount_next    = ecount_reg;

        cmd.op    = CELL_HOLD;
        cmd.pos   = position;
        cmd.count = count_reg;
        cmd.value = value;

        if (rsp_take)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next     = action;
                    pos_next     = position;
                    val_next     = value;
                    hit_next     = 1'b0;
                    res_st_next  = ST_OK;
                    res_pos_next = '0;
                    res_rd_next  = '0;
                    state_next   = S_DONE;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (position > count_reg)
                            begin
                                res_st_next = ST_BADPOS;
                            end
                            else if (count_reg >= CAP_COUNT)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (position >= count_reg)
                            begin
                                res_st_next = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.op     = CELL_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (position >= count_reg)
                            begin
                                res_st_next = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.op = CELL_WRITE;
                            end
                        end
                        ACT_READ:
                        begin
                            if (position >= count_reg)
                            begin
                                res_st_next = ST_BADPOS;
                            end
                            else
                            begin
                                state_next = S_ROTATE;
                            end
                        end
                        ACT_FIND:
                        begin
                            res_st_next = ST_MISSING;
                            state_next  = S_ROTATE;
                        end
                        default:
                        begin
                            res_st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ROTATE:
            begin
                // head holds entry step_reg of the list this cycle
                cmd.op = CELL_ROTATE;
                if (act_reg == ACT_FIND)
                begin
                    if (!hit_reg && COUNT_W'(step_reg) < count_reg && head == val_reg)
                    begin
                        hit_next     = 1'b1;
                        res_st_next  = ST_OK;
                        res_pos_next = POS_W'(step_reg);
                    end
                end
                else if (POS_W'(step_reg) == pos_reg)
                begin
                    res_rd_next = head;
                end
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_st_reg;
                    found_next     = res_pos_reg;
                    read_next      = res_rd_reg;
                    ecount_next    = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        res_st_reg  <= res_st_next;
        res_pos_reg <= res_pos_next;
        res_rd_reg  <= res_rd_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        read_reg    <= read_next;
        ecount_reg  <= ecount_next;
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = read_reg;
    assign entry_count    = ecount_reg;

    `IAL_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CAP_COUNT, "live count above capacity")
    `IAL_ASSERT_NXT(a_accept_busy, req_take, state_reg != S_IDLE, "accept left sequencer idle")
    `IAL_ASSERT_IMP(a_step_idle, state_reg != S_ROTATE, step_reg == '0, "step counter not parked")
    `IAL_ASSERT_NXT(a_count_hold, !req_take, $stable(count_reg), "count moved without request")
    `IAL_ASSERT_NXT(a_done_out, state_reg == S_DONE && !rsp_stall, rsp_valid, "result not issued")

endmodule
